// ===== rtl/core/qph_pkg.sv =====
// Shared types, constants and helpers for the quadratic-probe hash table core.
// No dependencies; imported by qph_store and quadratic_probe_hash_table_core.
`timescale 1ns / 1ps

package qph_pkg;

  localparam int TABLE_SIZE = 11;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;
  localparam int VALUE_W    = 64;
  localparam int SLOT_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int FOLD_W     = 8;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_FIND   = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_HOME,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_t;

  // write request into the slot store
  typedef struct packed {
    logic               en;
    idx_t               idx;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } wr_t;

  // a < 2*TABLE_SIZE in, a mod TABLE_SIZE out: one compare and subtract
  function automatic idx_t mod_reduce(input logic [IDX_W:0] a);
    logic [IDX_W:0] t;
    t = a - (IDX_W+1)'(TABLE_SIZE);
    if (a >= (IDX_W+1)'(TABLE_SIZE)) begin
      return t[IDX_W-1:0];
    end
    return a[IDX_W-1:0];
  endfunction

  // 32 = -1 mod 11: alternating sum of 5-bit key digits, offset by 99 (9 * 11)
  // so it stays positive; result in 6..193, same residue as the key
  function automatic logic [FOLD_W-1:0] fold_key(input logic [KEY_W-1:0] k);
    logic [6:0] pos;
    logic [6:0] neg;
    pos = 7'(k[4:0]) + 7'(k[14:10]) + 7'(k[24:20]) + 7'(k[30]);
    neg = 7'(k[9:5]) + 7'(k[19:15]) + 7'(k[29:25]);
    return FOLD_W'(pos) + FOLD_W'(99) - FOLD_W'(neg);
  endfunction

  // folded value in, same residue below 2*TABLE_SIZE out (feeds mod_reduce)
  function automatic logic [IDX_W:0] fold_small(input logic [FOLD_W-1:0] t);
    logic [5:0] u;
    u = 6'(t[4:0]) + 6'd11 - 6'(t[7:5]);
    if (u >= 6'd22) begin
      u = u - 6'd22;
    end
    return u[IDX_W:0];
  endfunction

endpackage

// ===== rtl/core/qph_store.sv =====
// Slot store: per-slot valid flags (cleared at reset) plus key/value memory.
// Registered read, one write port. Depends on qph_pkg.
`timescale 1ns / 1ps

module qph_store
  import qph_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  wr_t                wr,
  input  logic               rd_en,
  input  idx_t               rd_idx,
  output logic               rd_valid,
  output logic [KEY_W-1:0]   rd_key,
  output logic [VALUE_W-1:0] rd_value
);

  logic [TABLE_SIZE-1:0] valid;
  logic [KEY_W-1:0]      key_mem   [TABLE_SIZE];
  logic [VALUE_W-1:0]    value_mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.idx]   <= wr.key;
      value_mem[wr.idx] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= valid[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_idx];
      rd_value <= value_mem[rd_idx];
    end
  end

endmodule

// ===== rtl/core/quadratic_probe_hash_table_core.sv =====
// Channel   Dir  tdata (low bit up)                    tuser
// s_axis    in   key[30:0], value[94:31], pad[95]      action (0 insert, 1 find)
// m_axis    out  slot[3:0], found_value[67:4], pad     status (0 ok, 1 miss, 2 full)
//
// One item at a time: accept, fold the key by 5-bit digits, finish key mod 11
// through the shared reduce unit, then per probe a store read and a check, then
// load the result. Result register frees the input side; a stalled result only
// holds the next item at its result cycle. Synchronous reset empties every slot
// at once.
`timescale 1ns / 1ps

module quadratic_probe_hash_table_core
  import qph_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // key[30:0], value[94:31], zero pad
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // slot[3:0], found_value[67:4], zero pad
  output logic [1:0]  m_axis_tuser    // status
);

  state_t state, state_next;

  action_t            action_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;
  logic [FOLD_W-1:0]  fold_q;
  idx_t               cur_slot;
  idx_t               delta;
  idx_t               probe_i;

  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [VALUE_W-1:0] res_fv;

  logic               out_free;
  logic               rd_en;
  wr_t                wr;
  logic               rd_valid;
  logic [KEY_W-1:0]   rd_key;
  logic [VALUE_W-1:0] rd_value;

  logic [IDX_W:0]     red_in;
  idx_t               red_out;
  logic               hit;
  logic               last_probe;
  logic               probe_done;

  qph_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (rd_en),
    .rd_idx   (cur_slot),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // shared reduce unit: home slot from the folded key, slot advance while probing
  always_comb begin
    if (state == ST_HOME) begin
      red_in = fold_small(fold_q);
    end else begin
      red_in = {1'b0, cur_slot} + {1'b0, delta};
    end
    red_out = mod_reduce(red_in);
  end

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign hit        = rd_valid && (rd_key == key_q);
  assign last_probe = (probe_i == idx_t'(TABLE_SIZE - 1));
  assign probe_done = !rd_valid || (action_q == ACT_FIND && hit) || last_probe;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_FOLD;
      ST_FOLD:  state_next = ST_HOME;
      ST_HOME:  state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = probe_done ? ST_RESP : ST_READ;
      ST_RESP:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    rd_en         = (state == ST_READ);
    wr.en         = (state == ST_CHECK) && (action_q == ACT_INSERT) && !rd_valid;
    wr.idx        = cur_slot;
    wr.key        = key_q;
    wr.value      = value_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RESP && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        action_q <= action_t'(s_axis_tuser);
        key_q    <= s_axis_tdata[KEY_W-1:0];
        value_q  <= s_axis_tdata[KEY_W+VALUE_W-1:KEY_W];
      end
      ST_FOLD: begin
        fold_q <= fold_key(key_q);
      end
      ST_HOME: begin
        // home slot; i = 0, step to next square is 1
        cur_slot <= red_out;
        delta    <= idx_t'(1);
        probe_i  <= '0;
      end
      ST_READ: begin
      end
      ST_CHECK: begin
        res_status <= (action_q == ACT_INSERT) ? STS_FULL : STS_NOT_FOUND;
        res_slot   <= '0;
        res_fv     <= '0;
        if (action_q == ACT_INSERT && !rd_valid) begin
          res_status <= STS_OK;
          res_slot   <= SLOT_W'(cur_slot);
        end else if (action_q == ACT_FIND && hit) begin
          res_status <= STS_OK;
          res_slot   <= SLOT_W'(cur_slot);
          res_fv     <= rd_value;
        end
        // (i+1)^2 = i^2 + (2i+1)
        cur_slot <= red_out;
        delta    <= mod_reduce({1'b0, delta} + (IDX_W+1)'(2));
        probe_i  <= probe_i + 1'b1;
      end
      ST_RESP: begin
        if (out_free) begin
          m_axis_tuser <= res_status;
          m_axis_tdata <= {4'b0, res_fv, res_slot};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (cur_slot < idx_t'(TABLE_SIZE)))
    else $error("probe slot out of range");

  a_write_only_empty: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == ST_CHECK && !rd_valid && action_q == ACT_INSERT))
    else $error("store write outside an insert into an empty slot");

  a_accept_starts_fold: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_FOLD))
    else $error("accepted item did not start the home slot fold");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_RESP))
    else $error("result raised outside the result state");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (probe_i < idx_t'(TABLE_SIZE)))
    else $error("more than TABLE_SIZE probes");
`endif

endmodule

// ===== tb/sv/quadratic_probe_hash_table_core_tb.sv =====
// Self-checking testbench for quadratic_probe_hash_table_core: directed and random
// insert/find items against a behavioral table model, with random idling on both sides.
// Depends on qph_pkg and the core RTL only.
`timescale 1ns / 1ps

module quadratic_probe_hash_table_core_tb;
  import qph_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_AT_ITEM = 400;
  localparam int HOLD_CYCLES  = 600;

  typedef struct packed {
    action_t            act;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } op_t;

  typedef struct packed {
    status_t            st;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] fv;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // key[30:0], value[94:31], zero pad
  logic        s_axis_tuser = 1'b0; // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // slot[3:0], found_value[67:4], zero pad
  logic [1:0]  m_axis_tuser;        // status

  quadratic_probe_hash_table_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow table
  bit                 tbl_valid [TABLE_SIZE];
  logic [KEY_W-1:0]   tbl_key   [TABLE_SIZE];
  logic [VALUE_W-1:0] tbl_value [TABLE_SIZE];

  op_t     pending_ops[$];
  lookup_t lookup_q[$];
  int      items_taken = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      err_count = 0;
  int      cycle_count = 0;
  bit      in_fire = 1'b0;

  // walk the quadratic probe sequence; insert claims the first empty slot,
  // find stops at the key or at an empty slot
  function automatic lookup_t probe_table(input op_t op);
    lookup_t r;
    int      home;
    int      s;
    int      i;
    bit      done;
    r.st   = (op.act == ACT_INSERT) ? STS_FULL : STS_NOT_FOUND;
    r.slot = '0;
    r.fv   = '0;
    home   = int'({1'b0, op.key} % 32'(TABLE_SIZE));
    done   = 1'b0;
    for (i = 0; i < TABLE_SIZE && !done; i++) begin
      s = (home + i * i) % TABLE_SIZE;
      if (!tbl_valid[s]) begin
        if (op.act == ACT_INSERT) begin
          tbl_valid[s] = 1'b1;
          tbl_key[s]   = op.key;
          tbl_value[s] = op.value;
          r.st   = STS_OK;
          r.slot = SLOT_W'(s);
        end
        done = 1'b1;
      end else if (op.act == ACT_FIND && tbl_key[s] == op.key) begin
        r.st   = STS_OK;
        r.slot = SLOT_W'(s);
        r.fv   = tbl_value[s];
        done   = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic add_op(input action_t act, input logic [KEY_W-1:0] key,
                        input logic [VALUE_W-1:0] value);
    op_t op;
    op.act   = act;
    op.key   = key;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  // sender: bursts of items separated by random gaps, some stretches with none
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    op_t op;
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        s_axis_tdata  <= {1'b0, op.value, op.key};
        s_axis_tuser  <= op.act;
        s_axis_tvalid <= 1'b1;
        items_sent++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 10);
          if ((items_sent / 150) % 3 == 1 || $urandom_range(0, 2) == 0) begin
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(1, 60);
          end
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern by window, plus one long hold-off to back up the input
  int  rcv_cycle = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    rcv_cycle++;
    if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rcv_cycle / 1500) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((rcv_cycle % 23) > 15);
      endcase
    end
  end

  // monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    op_t     op;
    lookup_t want;
    lookup_t got;
    in_fire = !rst && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      op.act   = action_t'(s_axis_tuser);
      op.key   = s_axis_tdata[30:0];
      op.value = s_axis_tdata[94:31];
      lookup_q.push_back(probe_table(op));
      items_taken++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.st   = status_t'(m_axis_tuser);
      got.slot = m_axis_tdata[3:0];
      got.fv   = m_axis_tdata[67:4];
      results_seen++;
      if (lookup_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("%0t: unexpected result %0d: status %0d slot %0d value %h",
                   $realtime, results_seen, got.st, got.slot, got.fv);
        end
      end else begin
        want = lookup_q.pop_front();
        if (got.st !== want.st || got.slot !== want.slot || got.fv !== want.fv) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: result %0d mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                     $realtime, results_seen, want.st, got.st, want.slot, got.slot);
            $display("    found_value exp %h got %h", want.fv, got.fv);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quadratic_probe_hash_table_core_tb: FAIL");
      $finish;
    end
  end

  logic [KEY_W-1:0] known_keys[$];

  initial begin
    int               n;
    int               pick;
    logic [KEY_W-1:0] k;
    logic [VALUE_W-1:0] v;

    for (n = 0; n < TABLE_SIZE; n++) begin
      tbl_valid[n] = 1'b0;
      tbl_key[n]   = '0;
      tbl_value[n] = '0;
    end

    // directed: empty table, home-0 cluster growing to full, duplicates,
    // probe exhaustion, extreme keys and values
    add_op(ACT_FIND,   31'd0,          {64{1'b1}});           // miss on empty slot
    add_op(ACT_INSERT, 31'd0,          {64{1'b1}});
    add_op(ACT_INSERT, 31'd11,         64'h0123_4567_89ab_cdef);
    add_op(ACT_INSERT, 31'h7fff_ffff,  64'd0);                 // largest key
    add_op(ACT_INSERT, 31'd11,         64'hfedc_ba98_7654_3210); // duplicate key
    add_op(ACT_FIND,   31'd11,         64'd0);                 // first copy wins
    add_op(ACT_FIND,   31'h7fff_ffff,  {64{1'b1}});
    add_op(ACT_FIND,   31'd0,          64'd0);
    add_op(ACT_FIND,   31'd22,         64'd0);                 // collides, then empty
    add_op(ACT_INSERT, 31'd33,         64'haaaa_aaaa_aaaa_aaaa);
    add_op(ACT_INSERT, 31'd44,         64'h5555_5555_5555_5555);
    add_op(ACT_INSERT, 31'd55,         64'h8000_0000_0000_0001);
    add_op(ACT_INSERT, 31'd66,         64'hdead_beef_cafe_f00d); // home-0 residues used up
    add_op(ACT_FIND,   31'd88,         64'd0);                 // all probes valid, no match
    add_op(ACT_FIND,   31'd55,         64'd0);
    add_op(ACT_FIND,   31'd66,         64'd0);
    add_op(ACT_INSERT, 31'd10,         64'h0000_0000_ffff_ffff);
    add_op(ACT_FIND,   31'd10,         64'd0);
    add_op(ACT_FIND,   31'h7fff_fff4,  64'd0);                 // same home as largest key
    known_keys = '{31'd0, 31'd11, 31'h7fff_ffff, 31'd33, 31'd44, 31'd55, 31'd10};

    // random: mostly finds of stored keys and their colliders, inserts spread thin
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      v    = {$urandom, $urandom};
      if (pick < 5) begin
        if ($urandom_range(0, 1) == 1) begin
          k = KEY_W'($urandom);
        end else begin
          k = known_keys[$urandom_range(0, known_keys.size() - 1)]
              + KEY_W'(TABLE_SIZE * $urandom_range(1, 40));
        end
        known_keys.push_back(k);
        add_op(ACT_INSERT, k, v);
      end else begin
        if (pick < 60) begin
          k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        end else if (pick < 85) begin
          k = known_keys[$urandom_range(0, known_keys.size() - 1)]
              + KEY_W'(TABLE_SIZE * $urandom_range(1, 40));
        end else begin
          k = KEY_W'($urandom);
        end
        add_op(ACT_FIND, k, v);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() > 0 || s_axis_tvalid || lookup_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("quadratic_probe_hash_table_core_tb: PASS");
    end else begin
      $display("quadratic_probe_hash_table_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qph_pkg.sv
rtl/core/qph_store.sv
rtl/core/quadratic_probe_hash_table_core.sv
tb/sv/quadratic_probe_hash_table_core_tb.sv
